@@ rtl/rte_pkg.sv @@
// ----------------------------------------------------------------------------
// rte_pkg
// Shared types and constants for the retransmission timeout estimator.
// ----------------------------------------------------------------------------
package rte_pkg;

  typedef enum logic [1:0] {
    OP_INIT     = 2'd0,
    OP_NEW_PKT  = 2'd1,
    OP_RESPONSE = 2'd2,
    OP_TIMEOUT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_RTO_MIN     = 2'd0,
    CFG_RTO_MAX     = 2'd1,
    CFG_MAX_RETRANS = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  localparam int CNT_W = 4;
  localparam int OP_W  = 2;
  localparam int IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_SAT           = 4'd15;
  localparam logic [CNT_W-1:0] MAX_RETRANS_RESET = 4'd3;

  // Wide enough to truncate to any supported time width
  localparam logic [63:0] DEV_INIT_C    = 64'd3000000;
  localparam logic [63:0] RTO_MIN_RST_C = 64'd2000000;
  localparam logic [63:0] RTO_MAX_RST_C = 64'd60000000;

endpackage

@@ rtl/rte_in_if.sv @@
// ----------------------------------------------------------------------------
// rte_in_if
// Event item channel: op code and measured round trip time.
// ----------------------------------------------------------------------------
interface rte_in_if #(
  parameter int TIME_WIDTH = 26
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            op;
  logic [TIME_WIDTH-1:0] measured_rtt;

  modport source (output valid, output op, output measured_rtt, input ready);
  modport sink   (input valid, input op, input measured_rtt, output ready);
endinterface

@@ rtl/rte_out_if.sv @@
// ----------------------------------------------------------------------------
// rte_out_if
// Result item channel: timeout, give-up flag and retry count.
// ----------------------------------------------------------------------------
interface rte_out_if #(
  parameter int TIME_WIDTH = 26
);
  logic                  valid;
  logic                  ready;
  logic [TIME_WIDTH-1:0] rto;
  logic                  give_up;
  logic [3:0]            retry_count;

  modport source (output valid, output rto, output give_up, output retry_count,
                  input ready);
  modport sink   (input valid, input rto, input give_up, input retry_count,
                  output ready);
endinterface

@@ rtl/rte_update.sv @@
// ----------------------------------------------------------------------------
// rte_update
// Next-state logic: estimator update, RTO backoff, clamp and retry count.
// ----------------------------------------------------------------------------
module rte_update #(
  parameter int TIME_WIDTH = 26
) (
  input  rte_pkg::op_t                  op,
  input  logic [TIME_WIDTH-1:0]         measured_rtt,
  input  logic [TIME_WIDTH+3:0]         srtt,
  input  logic [TIME_WIDTH+2:0]         dev,
  input  logic [TIME_WIDTH-1:0]         rto,
  input  logic [rte_pkg::CNT_W-1:0]     cnt,
  input  logic [TIME_WIDTH-1:0]         rto_min,
  input  logic [TIME_WIDTH-1:0]         rto_max,
  input  logic [rte_pkg::CNT_W-1:0]     max_retrans,
  output logic [TIME_WIDTH+3:0]         srtt_nxt,
  output logic [TIME_WIDTH+2:0]         dev_nxt,
  output logic [TIME_WIDTH-1:0]         rto_nxt,
  output logic [rte_pkg::CNT_W-1:0]     cnt_nxt,
  output logic                          give_up
);
  import rte_pkg::*;

  localparam int TW = TIME_WIDTH;
  localparam logic [TW+2:0] DEV_INIT = DEV_INIT_C[TW+2:0];

  logic [TW:0]          srtt_div8;
  logic signed [TW+1:0] err;
  logic [TW+1:0]        err_abs;
  logic [TW+3:0]        srtt_upd;
  logic [TW+2:0]        dev_upd;
  logic [TW+3:0]        sum_upd;
  logic [TW+3:0]        clamp_in;
  logic [TW+3:0]        min_ext;
  logic [TW+3:0]        max_ext;
  logic [TW-1:0]        clamped;
  logic [CNT_W-1:0]     cnt_inc;

  assign srtt_div8 = srtt[TW+3:3];
  assign err       = $signed({2'b00, measured_rtt}) - $signed({1'b0, srtt_div8});
  assign err_abs   = err[TW+1] ? (TW+2)'(0) - err : err;
  assign srtt_upd  = srtt + {{2{err[TW+1]}}, err};
  assign dev_upd   = dev + {1'b0, err_abs} - {2'b00, dev[TW+2:2]};
  assign sum_upd   = {3'b000, srtt_upd[TW+3:3]} + {1'b0, dev_upd};
  assign cnt_inc   = (cnt == CNT_SAT) ? CNT_SAT : cnt + CNT_W'(1);
  assign min_ext   = {4'b0000, rto_min};
  assign max_ext   = {4'b0000, rto_max};

  always_comb begin
    case (op)
      OP_INIT:     clamp_in = {1'b0, DEV_INIT};
      OP_RESPONSE: clamp_in = sum_upd;
      OP_TIMEOUT:  clamp_in = {3'b000, rto, 1'b0};
      default:     clamp_in = {4'b0000, rto};
    endcase
  end

  // The minimum check has priority when the limits cross
  always_comb begin
    if (clamp_in < min_ext) begin
      clamped = rto_min;
    end else if (clamp_in > max_ext) begin
      clamped = rto_max;
    end else begin
      clamped = clamp_in[TW-1:0];
    end
  end

  always_comb begin
    srtt_nxt = srtt;
    dev_nxt  = dev;
    rto_nxt  = rto;
    cnt_nxt  = cnt;
    give_up  = 1'b0;
    case (op)
      OP_INIT: begin
        srtt_nxt = '0;
        dev_nxt  = DEV_INIT;
        rto_nxt  = clamped;
        cnt_nxt  = '0;
      end
      OP_NEW_PKT: begin
        cnt_nxt = '0;
      end
      OP_RESPONSE: begin
        // Karn: no sample from a retransmitted packet
        if (cnt == '0) begin
          srtt_nxt = srtt_upd;
          dev_nxt  = dev_upd;
          rto_nxt  = clamped;
        end
      end
      OP_TIMEOUT: begin
        rto_nxt = clamped;
        cnt_nxt = cnt_inc;
        give_up = (cnt_inc > max_retrans);
      end
      default: begin
        cnt_nxt = cnt;
      end
    endcase
  end

endmodule

@@ rtl/rtt_retransmit_timeout_estimator.sv @@
// ----------------------------------------------------------------------------
// rtt_retransmit_timeout_estimator
// Jacobson-Karels RTO estimator with Karn's rule and exponential backoff.
// ----------------------------------------------------------------------------
// Path: an accepted item goes through the input register, then the result reg.
// Throughput: one item per cycle while out_if.ready does not stall; the state update closes through one register.
// Reset (sync, rst_n low): registers to 2000000 / 60000000 / 3, estimators,
// RTO and retry count to their initial values; no clearing pass.
// ----------------------------------------------------------------------------
module rtt_retransmit_timeout_estimator #(
  parameter int TIME_WIDTH = 26
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rte_in_if.sink                        in_if,
  rte_out_if.source                     out_if,
  input  logic                          cfg_we,
  input  logic [rte_pkg::IDX_W-1:0]     cfg_idx,
  input  logic [TIME_WIDTH-1:0]         cfg_wdata
);
  import rte_pkg::*;

  localparam int TW = TIME_WIDTH;
  localparam logic [TW+2:0] DEV_INIT    = DEV_INIT_C[TW+2:0];
  localparam logic [TW-1:0] RTO_MIN_RST = RTO_MIN_RST_C[TW-1:0];
  localparam logic [TW-1:0] RTO_MAX_RST = RTO_MAX_RST_C[TW-1:0];
  localparam logic [TW+2:0] RTO_RST_W =
    (DEV_INIT < {3'b000, RTO_MIN_RST}) ? {3'b000, RTO_MIN_RST} :
    (DEV_INIT > {3'b000, RTO_MAX_RST}) ? {3'b000, RTO_MAX_RST} : DEV_INIT;
  localparam logic [TW-1:0] RTO_RST = RTO_RST_W[TW-1:0];

  logic [TW-1:0]    rto_min_r;
  logic [TW-1:0]    rto_max_r;
  logic [CNT_W-1:0] max_retrans_r;

  logic             s1_valid_r;
  op_t              s1_op_r;
  logic [TW-1:0]    s1_rtt_r;

  logic [TW+3:0]    srtt_r, srtt_nxt;
  logic [TW+2:0]    dev_r, dev_nxt;
  logic [TW-1:0]    rto_r, rto_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             give_up_nxt;

  logic             out_valid_r;
  logic [TW-1:0]    out_rto_r;
  logic             out_give_up_r;
  logic [CNT_W-1:0] out_cnt_r;

  logic             out_free;
  logic             advance;

  assign out_free    = !out_valid_r || out_if.ready;
  assign advance     = s1_valid_r && out_free;
  assign in_if.ready = !s1_valid_r || out_free;

  assign out_if.valid       = out_valid_r;
  assign out_if.rto         = out_rto_r;
  assign out_if.give_up     = out_give_up_r;
  assign out_if.retry_count = out_cnt_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rto_min_r     <= RTO_MIN_RST;
      rto_max_r     <= RTO_MAX_RST;
      max_retrans_r <= MAX_RETRANS_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_RTO_MIN:     rto_min_r     <= cfg_wdata;
        CFG_RTO_MAX:     rto_max_r     <= cfg_wdata;
        CFG_MAX_RETRANS: max_retrans_r <= cfg_wdata[CNT_W-1:0];
        default:         rto_min_r     <= rto_min_r;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_op_r  <= op_t'(in_if.op);
      s1_rtt_r <= in_if.measured_rtt;
    end
  end

  rte_update #(
    .TIME_WIDTH (TW)
  ) u_update (
    .op           (s1_op_r),
    .measured_rtt (s1_rtt_r),
    .srtt         (srtt_r),
    .dev          (dev_r),
    .rto          (rto_r),
    .cnt          (cnt_r),
    .rto_min      (rto_min_r),
    .rto_max      (rto_max_r),
    .max_retrans  (max_retrans_r),
    .srtt_nxt     (srtt_nxt),
    .dev_nxt      (dev_nxt),
    .rto_nxt      (rto_nxt),
    .cnt_nxt      (cnt_nxt),
    .give_up      (give_up_nxt)
  );

  // Estimator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srtt_r <= '0;
      dev_r  <= DEV_INIT;
      rto_r  <= RTO_RST;
      cnt_r  <= '0;
    end else if (advance) begin
      srtt_r <= srtt_nxt;
      dev_r  <= dev_nxt;
      rto_r  <= rto_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rto_r     <= rto_nxt;
      out_give_up_r <= give_up_nxt;
      out_cnt_r     <= cnt_nxt;
    end
  end

endmodule
